// ----- design/lgs_pkg.sv -----
`default_nettype none

package lgs_pkg;

	// request codes
	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_READ    = 2'd1;
	localparam logic [1:0] REQ_ADVANCE = 2'd2;

	// register indexes of the configuration port
	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;

	// register widths and reset values
	localparam int         ROWS_REG_W = 7;
	localparam int         COLS_REG_W = 8;
	localparam int         CFG_DATA_W = 8;
	localparam logic [6:0] ROWS_RESET = 7'd50;
	localparam logic [7:0] COLS_RESET = 8'd105;

	// smallest region size that an advance works over
	localparam int MIN_SIZE = 3;

	// b3/s23 neighbor counts
	localparam logic [3:0] NBR_BIRTH = 4'd3;
	localparam logic [3:0] NBR_KEEP  = 4'd2;

	// width of a size count: holds the register and the maximum itself
	function automatic int cnt_width(input int maxv, input int regw);
		int w;
		w = $clog2(maxv + 1);
		return (w > regw) ? w : regw;
	endfunction

	// microprogram step labels
	typedef enum logic [3:0] {
		S_IDLE    = 4'd0,
		S_WR_RD   = 4'd1,
		S_WR_WR   = 4'd2,
		S_RD_RD   = 4'd3,
		S_RD_EMIT = 4'd4,
		S_ADV0    = 4'd5,
		S_ADV1    = 4'd6,
		S_ADV2    = 4'd7,
		S_ADV_ROW = 4'd8,
		S_ADV_END = 4'd9,
		S_BAD     = 4'd10
	} step_t;

	// row read address select
	typedef enum logic [2:0] {
		RD_NONE,
		RD_REQ,
		RD_LAST,
		RD_FIRST,
		RD_NEXT1,
		RD_NEXT2
	} rd_sel_t;

	// row write select
	typedef enum logic [1:0] {
		WR_NONE,
		WR_CELL,
		WR_GEN
	} wr_sel_t;

	// window register loads
	typedef enum logic [1:0] {
		LD_NONE,
		LD_UP,
		LD_CUR,
		LD_SHIFT
	} ld_sel_t;

	// result word to emit
	typedef enum logic [1:0] {
		EM_NONE,
		EM_DONE,
		EM_READ,
		EM_BAD
	} emit_t;

	// sequencer branch kinds
	typedef enum logic [1:0] {
		J_NEXT,
		J_GOTO,
		J_START,
		J_LOOP
	} jmp_t;

	// one control word
	typedef struct packed {
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		ld_sel_t ld_sel;
		logic    row_clr;
		emit_t   emit;
		jmp_t    jmp;
		step_t   target;
	} ctrl_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic       start;
		logic [1:0] req_type;
		logic       last_row;
	} stat_t;

endpackage

`default_nettype wire

// ----- design/lgs_ram.sv -----
`default_nettype none

module lgs_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  wire  [WIDTH-1:0]          wdata,
	input  wire                       re,
	input  wire  [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/lgs_rule.sv -----
`default_nettype none

module lgs_rule #(
	parameter int MAX_COLS = 128
) (
	input  wire  [MAX_COLS-1:0]                                       up_row,
	input  wire  [MAX_COLS-1:0]                                       cur_row,
	input  wire  [MAX_COLS-1:0]                                       dn_row,
	input  wire  [lgs_pkg::cnt_width(MAX_COLS, lgs_pkg::COLS_REG_W)-1:0] nc,
	output logic [MAX_COLS-1:0]                                       new_row
);

	import lgs_pkg::*;

	localparam int NCW  = cnt_width(MAX_COLS, COLS_REG_W);
	localparam int CA_W = $clog2(MAX_COLS);

	logic [CA_W-1:0] edge_idx;
	logic            up_e;
	logic            cur_e;
	logic            dn_e;

	// cells of the last column in use, left neighbors of column zero
	assign edge_idx = CA_W'(nc - NCW'(1));
	assign up_e     = up_row[edge_idx];
	assign cur_e    = cur_row[edge_idx];
	assign dn_e     = dn_row[edge_idx];

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		logic [2:0] lf;
		logic [2:0] rt;
		logic [3:0] cnt;
		logic       in_reg;
		logic       is_last;

		assign in_reg  = NCW'(c) < nc;
		assign is_last = NCW'(c + 1) == nc;

		// left column, wrapping at column zero
		if (c == 0) begin : g_lf_wrap
			assign lf = {up_e, cur_e, dn_e};
		end else begin : g_lf
			assign lf = {up_row[c-1], cur_row[c-1], dn_row[c-1]};
		end

		// right column, wrapping at the last column in use
		if (c == MAX_COLS - 1) begin : g_rt_wrap
			assign rt = {up_row[0], cur_row[0], dn_row[0]};
		end else begin : g_rt
			assign rt = is_last ? {up_row[0], cur_row[0], dn_row[0]}
			                    : {up_row[c+1], cur_row[c+1], dn_row[c+1]};
		end

		// live neighbor count
		assign cnt = 4'(lf[0]) + 4'(lf[1]) + 4'(lf[2]) + 4'(rt[0]) + 4'(rt[1])
		           + 4'(rt[2]) + 4'(up_row[c]) + 4'(dn_row[c]);

		// birth on three, survival on two or three; outside the region hold
		assign new_row[c] = in_reg ? ((cnt == NBR_BIRTH) || (cur_row[c] && cnt == NBR_KEEP))
		                           : cur_row[c];
	end

endmodule

`default_nettype wire

// ----- design/lgs_seq.sv -----
`default_nettype none

module lgs_seq (
	input  wire            clk,
	input  wire            arst_n,
	input  lgs_pkg::stat_t stat,
	output lgs_pkg::ctrl_t ctrl,
	output logic           busy
);

	import lgs_pkg::*;

	step_t upc_q;
	step_t upc_d;

	// control store
	function automatic ctrl_t rom(input step_t s);
		ctrl_t w;
		w = '{rd_sel: RD_NONE, wr_sel: WR_NONE, ld_sel: LD_NONE, row_clr: 1'b0,
		      emit: EM_NONE, jmp: J_GOTO, target: S_IDLE};
		case (s)
			S_IDLE: begin
				w.jmp = J_START;
			end
			S_WR_RD: begin
				w.rd_sel = RD_REQ;
				w.jmp    = J_NEXT;
			end
			S_WR_WR: begin
				w.wr_sel = WR_CELL;
				w.emit   = EM_DONE;
			end
			S_RD_RD: begin
				w.rd_sel = RD_REQ;
				w.jmp    = J_NEXT;
			end
			S_RD_EMIT: begin
				w.emit = EM_READ;
			end
			S_ADV0: begin
				w.rd_sel  = RD_LAST;
				w.row_clr = 1'b1;
				w.jmp     = J_NEXT;
			end
			S_ADV1: begin
				w.rd_sel = RD_FIRST;
				w.ld_sel = LD_UP;
				w.jmp    = J_NEXT;
			end
			S_ADV2: begin
				w.rd_sel = RD_NEXT1;
				w.ld_sel = LD_CUR;
				w.jmp    = J_NEXT;
			end
			S_ADV_ROW: begin
				w.rd_sel = RD_NEXT2;
				w.wr_sel = WR_GEN;
				w.ld_sel = LD_SHIFT;
				w.jmp    = J_LOOP;
				w.target = S_ADV_ROW;
			end
			S_ADV_END: begin
				w.emit = EM_DONE;
			end
			S_BAD: begin
				w.emit = EM_BAD;
			end
			default: begin
				w.jmp = J_GOTO;
			end
		endcase
		return w;
	endfunction

	assign ctrl = rom(upc_q);
	assign busy = upc_q != S_IDLE;

	// next step
	always_comb begin
		upc_d = upc_q;
		case (ctrl.jmp)
			J_NEXT: begin
				upc_d = step_t'(upc_q + 4'd1);
			end
			J_GOTO: begin
				upc_d = ctrl.target;
			end
			J_START: begin
				if (stat.start) begin
					case (stat.req_type)
						REQ_WRITE:   upc_d = S_WR_RD;
						REQ_READ:    upc_d = S_RD_RD;
						REQ_ADVANCE: upc_d = S_ADV0;
						default:     upc_d = S_BAD;
					endcase
				end
			end
			J_LOOP: begin
				upc_d = stat.last_row ? step_t'(upc_q + 4'd1) : ctrl.target;
			end
			default: begin
				upc_d = S_IDLE;
			end
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/life_generation_step.sv -----
// channel  | ports                                          | handshake
// ---------+------------------------------------------------+--------------------------
// request  | req_type, row_index, col_index, cell_in        | start & !busy
// result   | cell_out, done_res                             | res_strobe, one cycle
// config   | cfg_index, cfg_data                            | cfg_we, no wait
//
// a write request reads its row and writes it back with the new cell, a read
// request reads its row and shows the cell; an advance takes one row word per
// cycle through the single row memory port pair. busy is high from the accept
// until the result. reset clears the row valid flags at once, so every row reads
// dead with no clearing pass; configuration defaults to 50 rows and 105 columns.
// the result receiver cannot stall; each result is shown for one cycle.
`default_nettype none

module life_generation_step #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 128
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire  [1:0] req_type,
	input  wire  [5:0] row_index,
	input  wire  [6:0] col_index,
	input  wire        cell_in,
	output logic       res_strobe,
	output logic       cell_out,
	output logic       done_res,
	input  wire        cfg_we,
	input  wire  [1:0] cfg_index,
	input  wire  [7:0] cfg_data
);

	import lgs_pkg::*;

	localparam int RA_W = $clog2(MAX_ROWS);
	localparam int CA_W = $clog2(MAX_COLS);
	localparam int NRW  = cnt_width(MAX_ROWS, ROWS_REG_W);
	localparam int NCW  = cnt_width(MAX_COLS, COLS_REG_W);

	ctrl_t ctrl;
	stat_t stat;
	logic  accept;

	logic [ROWS_REG_W-1:0] rows_q;
	logic [COLS_REG_W-1:0] cols_q;
	logic [NRW-1:0]        rows_ext;
	logic [NCW-1:0]        cols_ext;
	logic [NRW-1:0]        nr;
	logic [NCW-1:0]        nc;
	logic [RA_W-1:0]       last_ra;

	logic            in_grid;
	logic            in_grid_q;
	logic [RA_W-1:0] req_ra_q;
	logic [CA_W-1:0] req_ca_q;
	logic            req_cell_q;

	logic [RA_W-1:0]     row_q;
	logic [NRW:0]        next2;
	logic                last_row;
	logic [MAX_COLS-1:0] up_q;
	logic [MAX_COLS-1:0] cur_q;
	logic [MAX_COLS-1:0] first_q;
	logic [MAX_ROWS-1:0] row_valid_q;
	logic                rd_valid_q;

	logic                rd_en;
	logic [RA_W-1:0]     rd_addr;
	logic [MAX_COLS-1:0] rd_data;
	logic [MAX_COLS-1:0] rd_word;
	logic [MAX_COLS-1:0] dn_word;
	logic [MAX_COLS-1:0] gen_row;
	logic                wr_en;
	logic [RA_W-1:0]     wr_addr;
	logic [MAX_COLS-1:0] wr_data;
	logic [MAX_COLS-1:0] cell_word;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data[ROWS_REG_W-1:0];
				CFG_COLS: cols_q <= cfg_data[COLS_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// region size, clamped to the grid
	assign rows_ext = NRW'(rows_q);
	assign cols_ext = NCW'(cols_q);
	assign nr = (rows_ext < NRW'(MIN_SIZE)) ? NRW'(MIN_SIZE)
	          : (rows_ext > NRW'(MAX_ROWS)) ? NRW'(MAX_ROWS) : rows_ext;
	assign nc = (cols_ext < NCW'(MIN_SIZE)) ? NCW'(MIN_SIZE)
	          : (cols_ext > NCW'(MAX_COLS)) ? NCW'(MAX_COLS) : cols_ext;
	assign last_ra  = RA_W'(nr - NRW'(1));
	assign last_row = row_q == last_ra;

	// sequencer
	assign accept        = start && !busy;
	assign stat.start    = start;
	assign stat.req_type = req_type;
	assign stat.last_row = last_row;

	lgs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// request latch; an address beyond the grid is parked on cell zero
	assign in_grid = (32'(row_index) < 32'(MAX_ROWS)) && (32'(col_index) < 32'(MAX_COLS));

	always_ff @(posedge clk) begin
		if (accept) begin
			in_grid_q  <= in_grid;
			req_ra_q   <= in_grid ? RA_W'(row_index) : '0;
			req_ca_q   <= in_grid ? CA_W'(col_index) : '0;
			req_cell_q <= cell_in;
		end
	end

	// row read address
	assign next2 = (NRW+1)'(row_q) + (NRW+1)'(2);

	always_comb begin
		rd_en   = 1'b1;
		rd_addr = '0;
		case (ctrl.rd_sel)
			RD_REQ:   rd_addr = req_ra_q;
			RD_LAST:  rd_addr = last_ra;
			RD_FIRST: rd_addr = '0;
			RD_NEXT1: rd_addr = row_q + RA_W'(1);
			RD_NEXT2: rd_addr = (next2 < (NRW+1)'(nr)) ? RA_W'(next2) : '0;
			default:  rd_en   = 1'b0;
		endcase
	end

	// read word; a row never written reads dead
	assign rd_word = rd_valid_q ? rd_data : '0;
	assign dn_word = last_row ? first_q : rd_word;

	// single cell update of the fetched row
	always_comb begin
		cell_word           = rd_word;
		cell_word[req_ca_q] = req_cell_q;
	end

	lgs_rule #(
		.MAX_COLS (MAX_COLS)
	) u_rule (
		.up_row  (up_q),
		.cur_row (cur_q),
		.dn_row  (dn_word),
		.nc      (nc),
		.new_row (gen_row)
	);

	// row write select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = row_q;
		wr_data = gen_row;
		case (ctrl.wr_sel)
			WR_CELL: begin
				wr_en   = in_grid_q;
				wr_addr = req_ra_q;
				wr_data = cell_word;
			end
			WR_GEN: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	lgs_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_grid (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// row valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= row_valid_q[rd_addr];
			end
		end
	end

	// three-row window and row counter
	always_ff @(posedge clk) begin
		if (ctrl.row_clr) begin
			row_q <= '0;
		end
		case (ctrl.ld_sel)
			LD_UP: begin
				up_q <= rd_word;
			end
			LD_CUR: begin
				cur_q   <= rd_word;
				first_q <= rd_word;
			end
			LD_SHIFT: begin
				up_q  <= cur_q;
				cur_q <= dn_word;
				row_q <= row_q + RA_W'(1);
			end
			default: begin
			end
		endcase
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_strobe <= 1'b0;
			cell_out   <= 1'b0;
			done_res   <= 1'b0;
		end else begin
			res_strobe <= ctrl.emit != EM_NONE;
			cell_out   <= (ctrl.emit == EM_READ) && in_grid_q && rd_word[req_ca_q];
			done_res   <= (ctrl.emit == EM_DONE) || (ctrl.emit == EM_READ);
		end
	end

endmodule

`default_nettype wire
